[design/tdcewd_pkg.sv]
// Shared types and constants of the event word decoder.
`default_nettype none

package tdcewd_pkg;

   localparam int unsigned CHANNELS_DEFAULT = 4;
   localparam int unsigned WORD_W           = 32;
   localparam int unsigned UPPER_W          = 24;
   localparam int unsigned EDGE_W           = 17;
   localparam int unsigned TOT_W            = 18;
   localparam int unsigned HIT_W            = 8;
   localparam int unsigned TIME_W           = 63;
   localparam int unsigned NET_W            = 62;
   localparam int unsigned SEC_W            = 30;
   localparam int unsigned WINDOW_W         = 40;
   localparam int unsigned CFG_W            = 40;
   localparam int unsigned CFG_INDEX_W      = 1;
   localparam int unsigned CHAN_W           = 2;
   localparam int unsigned CHAN_FIELD_W     = 8;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam logic [7:0]  TOP_HEADER     = 8'h5c;
   localparam logic [7:0]  TOP_LEAD       = 8'h03;
   localparam logic [7:0]  TOP_TRAIL      = 8'h04;
   localparam logic [31:0] WORD_TRAILER   = 32'hff55_0000;
   localparam logic [31:0] WORD_STATUS_OK = 32'h0003_0000;
   localparam logic [31:0] WORD_KEYWORD   = 32'h7fff_000a;

   localparam logic signed [EDGE_W-1:0] NO_EDGE            = -17'sd100;
   localparam logic [HIT_W-1:0]         HIT_LIMIT_RESET    = 8'd10;
   localparam logic [WINDOW_W-1:0]      PULSE_WINDOW_RESET = 40'd2147484;

   // 25 ns ticks to 2^-32 s: round(t25 * 2^24 / 156250)
   //   = 107 * t25 + floor((58466 * t25 + 78125) / 156250)
   localparam int unsigned T25_W     = 11;
   localparam int unsigned T32K_W    = 15;
   localparam int unsigned PART_W    = 27;
   localparam int unsigned PROD_W    = 47;
   localparam int unsigned QPART_W   = 10;
   localparam int unsigned FRAC_W    = 33;
   localparam int unsigned T25_SHIFT = 37;
   localparam logic [6:0]  T25_WHOLE = 7'd107;
   localparam logic [15:0] T25_PART  = 16'd58466;
   localparam logic [16:0] T25_HALF  = 17'd78125;
   localparam logic [17:0] T25_DIV   = 18'd156250;
   localparam logic [19:0] T25_RECIP = 20'd879609;

   typedef enum logic [CFG_INDEX_W-1:0] {
      REG_HIT_LIMIT    = 1'b0,
      REG_PULSE_WINDOW = 1'b1
   } reg_index_type;

   typedef enum logic {
      OP_TRIGGER = 1'b0,
      OP_STATUS  = 1'b1
   } op_kind_type;

   typedef enum logic [3:0] {
      EXP_NORMAL  = 4'b0001,
      EXP_TIME    = 4'b0010,
      EXP_STATUS  = 4'b0100,
      EXP_KEYWORD = 4'b1000
   } expect_type;

   typedef struct packed {
      logic               valid;
      op_kind_type        kind;
      logic [UPPER_W-1:0] upper;
      logic [WORD_W-1:0]  lower;
      logic               ok;
   } front_op_type;

   typedef struct packed {
      logic [EDGE_W-1:0] lead;
      logic [EDGE_W-1:0] trail;
      logic [HIT_W-1:0]  hits;
   } chan_store_type;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] sync;
      logic              ok;
   } stamp_set_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [EDGE_W-1:0] lead;
      logic [EDGE_W-1:0] trail;
      logic [TOT_W-1:0]  over;
      logic [HIT_W-1:0]  hits;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] gap;
      logic [TIME_W-1:0] sync;
      logic              ok;
      logic              last;
   } out_rec_type;

endpackage

`default_nettype wire

[design/tdc_event_word_decoder.sv]
// Top level of the data-acquisition event word decoder.
// Takes one 32-bit readout word per cycle. A header word and the word after it
// give the trigger time, which a six-stage time pipeline converts to fixed point
// (32 fraction bits) and turns into stamp, trigger gap and double-pulse stamp.
// Edge words inside an event update per-channel stores as they arrive. The
// status word after a trailer releases CHANNELS records through the snapshot
// queue, one per cycle from the output register while rsp_tready is high. A
// two-entry snapshot queue separates the time pipeline from the record output;
// req_tready drops only while a status word waits at the pipeline end with
// that queue full. Configuration writes are taken in every cycle.
`default_nettype none

module tdc_event_word_decoder #(
   parameter int unsigned CHANNELS = tdcewd_pkg::CHANNELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tdcewd_pkg::WORD_W-1:0]      req_tdata,   // raw_word
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // lead_time, trail_time, over_threshold, hit_count, stamp, trigger_gap,
   // sync_stamp, zero fill
   output logic [255:0]                       rsp_tdata,
   output logic [2:0]                         rsp_tuser,   // channel, event_ok
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tdcewd_pkg::CFG_INDEX_W-1:0] csr_index,
   input  logic [tdcewd_pkg::CFG_W-1:0]       csr_data
);
   import tdcewd_pkg::*;

   logic [HIT_W-1:0]    hit_limit_ff, hit_limit_in;
   logic [WINDOW_W-1:0] pulse_window_ff, pulse_window_in;

   front_op_type                  op;
   chan_store_type [CHANNELS-1:0] op_stores;
   logic                          advance;
   logic                          push;
   stamp_set_type                 push_stamps;
   chan_store_type [CHANNELS-1:0] push_stores;
   logic                          queue_full;
   logic                          head_valid;
   stamp_set_type                 head_stamps;
   chan_store_type [CHANNELS-1:0] head_stores;
   logic                          pop;
   out_rec_type                   rec;

   assign csr_ready = 1'b1;

   always_comb begin
      hit_limit_in    = hit_limit_ff;
      pulse_window_in = pulse_window_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_HIT_LIMIT: begin
               hit_limit_in = csr_data[HIT_W-1:0];
            end
            REG_PULSE_WINDOW: begin
               pulse_window_in = csr_data[WINDOW_W-1:0];
            end
            default: begin
               hit_limit_in = hit_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_limit_ff    <= HIT_LIMIT_RESET;
         pulse_window_ff <= PULSE_WINDOW_RESET;
      end else begin
         hit_limit_ff    <= hit_limit_in;
         pulse_window_ff <= pulse_window_in;
      end
   end

   tdcewd_front #(.CHANNELS(CHANNELS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .word_valid (req_tvalid),
      .word_ready (req_tready),
      .word       (req_tdata),
      .hit_limit  (hit_limit_ff),
      .advance    (advance),
      .op         (op),
      .op_stores  (op_stores)
   );

   tdcewd_time #(.CHANNELS(CHANNELS)) u_time (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .op_stores    (op_stores),
      .pulse_window (pulse_window_ff),
      .queue_full   (queue_full),
      .advance      (advance),
      .push         (push),
      .push_stamps  (push_stamps),
      .push_stores  (push_stores)
   );

   tdcewd_queue #(.CHANNELS(CHANNELS)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_stamps (push_stamps),
      .push_stores (push_stores),
      .pop         (pop),
      .full        (queue_full),
      .head_valid  (head_valid),
      .head_stamps (head_stamps),
      .head_stores (head_stores)
   );

   tdcewd_back #(.CHANNELS(CHANNELS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_stamps (head_stamps),
      .head_stores (head_stores),
      .pop         (pop),
      .rec_valid   (rsp_tvalid),
      .rec_ready   (rsp_tready),
      .rec         (rec)
   );

   assign rsp_tdata = {7'b0, rec.sync, rec.gap, rec.stamp, rec.hits,
                       rec.over, rec.trail, rec.lead};
   assign rsp_tuser = {rec.ok, rec.channel};
   assign rsp_tlast = rec.last;

endmodule

`default_nettype wire

[design/tdcewd_front.sv]
// Word classifier: expected-word tracking, per-channel edge stores and op issue.
`default_nettype none

module tdcewd_front #(
   parameter int unsigned CHANNELS = tdcewd_pkg::CHANNELS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      word_valid,
   output logic                                      word_ready,
   input  logic [tdcewd_pkg::WORD_W-1:0]             word,
   input  logic [tdcewd_pkg::HIT_W-1:0]              hit_limit,
   input  logic                                      advance,
   output tdcewd_pkg::front_op_type                  op,
   output tdcewd_pkg::chan_store_type [CHANNELS-1:0] op_stores
);
   import tdcewd_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   expect_type                  expect_ff, expect_in;
   logic                        in_event_ff, in_event_in;
   logic [UPPER_W-1:0]          header_ff, header_in;
   chan_store_type [CHANNELS-1:0] store_ff, store_in;
   front_op_type                op_ff, op_in;
   chan_store_type [CHANNELS-1:0] snap_ff;

   logic                    accept;
   logic [7:0]              top;
   logic [CHAN_FIELD_W-1:0] ch;
   logic                    in_range;
   logic [IDX_W-1:0]        sel;
   logic [EDGE_W-1:0]       edge_val;
   logic                    room;

   assign accept     = word_valid && advance;
   assign word_ready = advance;
   assign top        = word[31:24];
   assign ch         = word[23:16];
   assign in_range   = ch < CHAN_FIELD_W'(CHANNELS);
   assign sel        = ch[IDX_W-1:0];
   assign edge_val   = {1'b0, word[15:0]};
   assign room       = in_range && (store_ff[sel].hits < hit_limit);

   always_comb begin
      expect_in   = expect_ff;
      in_event_in = in_event_ff;
      header_in   = header_ff;
      store_in    = store_ff;
      op_in       = '0;
      if (accept) begin
         case (expect_ff)
            EXP_TIME: begin
               expect_in    = EXP_NORMAL;
               op_in.valid  = 1'b1;
               op_in.kind   = OP_TRIGGER;
               op_in.upper  = header_ff;
               op_in.lower  = word;
            end
            EXP_KEYWORD: begin
               expect_in = EXP_NORMAL;
            end
            EXP_STATUS: begin
               expect_in   = EXP_NORMAL;
               op_in.valid = 1'b1;
               op_in.kind  = OP_STATUS;
               op_in.ok    = (word == WORD_STATUS_OK);
            end
            EXP_NORMAL: begin
               if (top == TOP_HEADER) begin
                  in_event_in = 1'b1;
                  header_in   = word[UPPER_W-1:0];
                  expect_in   = EXP_TIME;
                  for (int c = 0; c < CHANNELS; c++) begin
                     store_in[c].lead  = NO_EDGE;
                     store_in[c].trail = NO_EDGE;
                     store_in[c].hits  = '0;
                  end
               end else if (word == WORD_KEYWORD) begin
                  expect_in = EXP_KEYWORD;
               end else if (in_event_ff) begin
                  if (top == TOP_LEAD || top == TOP_TRAIL) begin
                     if (room) begin
                        if (top == TOP_LEAD) begin
                           store_in[sel].lead = edge_val;
                        end else begin
                           store_in[sel].trail = edge_val;
                        end
                        store_in[sel].hits = store_ff[sel].hits + HIT_W'(1);
                     end
                  end else if (word == WORD_TRAILER) begin
                     in_event_in = 1'b0;
                     expect_in   = EXP_STATUS;
                  end
               end
            end
            default: begin
               expect_in = EXP_NORMAL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff   <= EXP_NORMAL;
         in_event_ff <= 1'b0;
         header_ff   <= '0;
         op_ff       <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            store_ff[c].lead  <= NO_EDGE;
            store_ff[c].trail <= NO_EDGE;
            store_ff[c].hits  <= '0;
         end
      end else begin
         expect_ff   <= expect_in;
         in_event_ff <= in_event_in;
         header_ff   <= header_in;
         store_ff    <= store_in;
         if (advance) begin
            op_ff <= op_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff <= store_ff;
      end
   end

   assign op        = op_ff;
   assign op_stores = snap_ff;

endmodule

`default_nettype wire

[design/tdcewd_time.sv]
// Time pipeline: network time conversion, stamp, gap and double pulse tracking.
`default_nettype none

module tdcewd_time #(
   parameter int unsigned CHANNELS = tdcewd_pkg::CHANNELS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tdcewd_pkg::front_op_type                  op,
   input  tdcewd_pkg::chan_store_type [CHANNELS-1:0] op_stores,
   input  logic [tdcewd_pkg::WINDOW_W-1:0]           pulse_window,
   input  logic                                      queue_full,
   output logic                                      advance,
   output logic                                      push,
   output tdcewd_pkg::stamp_set_type                 push_stamps,
   output tdcewd_pkg::chan_store_type [CHANNELS-1:0] push_stores
);
   import tdcewd_pkg::*;

   localparam int unsigned STAGES = 6;

   logic [STAGES:1] vld_ff;
   op_kind_type     kind_ff [1:STAGES];
   logic            ok_ff   [1:STAGES];
   chan_store_type [CHANNELS-1:0] snap_ff [1:STAGES];

   // datapath stage registers
   logic [PART_W-1:0]  m1_ff, m1_in, m2_ff;
   logic [FRAC_W-1:0]  fr1_ff, fr1_in, fr2_ff, fq3_ff, fq3_in;
   logic [SEC_W-1:0]   sec1_ff, sec1_in, sec2_ff, sec3_ff;
   logic [QPART_W-1:0] qe2_ff, qe2_in;
   logic [NET_W-1:0]   t4_ff, t4_in;
   logic [TIME_W-1:0]  stamp5_ff, stamp5_in, stamp6_ff, gap6_ff, gap6_in;

   // trigger state
   logic              seen_first_ff;
   logic [NET_W-1:0]  first_ff;
   logic [TIME_W-1:0] prev_ff;
   logic [TIME_W-1:0] cur_stamp_ff;
   logic [TIME_W-1:0] cur_gap_ff;
   logic [TIME_W-1:0] sync_ff;

   logic [T25_W-1:0]  t25;
   logic [T32K_W-1:0] t32k;
   logic [PROD_W-1:0] prod;
   logic [PART_W-1:0] rem;
   logic              corr;
   logic [TIME_W-1:0] sum;
   logic [TIME_W:0]   diff;
   logic              trig4, trig5, trig6, stat6;

   assign t25  = op.lower[T25_W-1:0];
   assign t32k = op.lower[T25_W +: T32K_W];

   assign sec1_in = {op.upper, op.lower[WORD_W-1:T25_W+T32K_W]};
   assign m1_in   = PART_W'(T25_PART) * PART_W'(t25) + PART_W'(T25_HALF);
   assign fr1_in  = {t32k, 17'b0} + FRAC_W'(T25_WHOLE) * FRAC_W'(t25);

   assign prod   = PROD_W'(m1_ff) * PROD_W'(T25_RECIP);
   assign qe2_in = prod[T25_SHIFT +: QPART_W];

   assign rem    = m2_ff - PART_W'(qe2_ff) * PART_W'(T25_DIV);
   assign corr   = rem >= PART_W'(T25_DIV);
   assign fq3_in = fr2_ff + FRAC_W'(qe2_ff) + FRAC_W'(corr);

   assign sum   = {1'b0, sec3_ff, 32'b0} + TIME_W'(fq3_ff);
   assign t4_in = sum[NET_W] ? {NET_W{1'b1}} : sum[NET_W-1:0];

   assign stamp5_in = seen_first_ff ? ({1'b0, t4_ff} - {1'b0, first_ff}) : '0;

   assign diff    = {stamp5_ff[TIME_W-1], stamp5_ff} - {prev_ff[TIME_W-1], prev_ff};
   assign gap6_in = (diff[TIME_W] != diff[TIME_W-1])
                  ? (diff[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}})
                  : diff[TIME_W-1:0];

   assign trig4 = vld_ff[4] && (kind_ff[4] == OP_TRIGGER);
   assign trig5 = vld_ff[5] && (kind_ff[5] == OP_TRIGGER);
   assign trig6 = vld_ff[6] && (kind_ff[6] == OP_TRIGGER);
   assign stat6 = vld_ff[6] && (kind_ff[6] == OP_STATUS);

   assign advance = !(stat6 && queue_full);
   assign push    = advance && stat6;

   assign push_stamps.stamp = cur_stamp_ff;
   assign push_stamps.gap   = cur_gap_ff;
   assign push_stamps.sync  = sync_ff;
   assign push_stamps.ok    = ok_ff[STAGES];
   assign push_stores       = snap_ff[STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-1:1], op.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff[1] <= op.kind;
         ok_ff[1]   <= op.ok;
         snap_ff[1] <= op_stores;
         for (int s = 2; s <= STAGES; s++) begin
            kind_ff[s] <= kind_ff[s-1];
            ok_ff[s]   <= ok_ff[s-1];
            snap_ff[s] <= snap_ff[s-1];
         end
         m1_ff     <= m1_in;
         fr1_ff    <= fr1_in;
         sec1_ff   <= sec1_in;
         qe2_ff    <= qe2_in;
         m2_ff     <= m1_ff;
         fr2_ff    <= fr1_ff;
         sec2_ff   <= sec1_ff;
         fq3_ff    <= fq3_in;
         sec3_ff   <= sec2_ff;
         t4_ff     <= t4_in;
         stamp5_ff <= stamp5_in;
         stamp6_ff <= stamp5_ff;
         gap6_ff   <= gap6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_first_ff <= 1'b0;
         first_ff      <= '0;
         prev_ff       <= '0;
         cur_stamp_ff  <= '0;
         cur_gap_ff    <= '0;
         sync_ff       <= '0;
      end else if (advance) begin
         if (trig4 && !seen_first_ff) begin
            seen_first_ff <= 1'b1;
            first_ff      <= t4_ff;
         end
         if (trig5) begin
            prev_ff <= stamp5_ff;
         end
         if (trig6) begin
            cur_stamp_ff <= stamp6_ff;
            cur_gap_ff   <= gap6_ff;
            if ($signed(gap6_ff) < $signed({{(TIME_W-WINDOW_W){1'b0}}, pulse_window})) begin
               sync_ff <= stamp6_ff;
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(seen_first_ff)) |-> seen_first_ff)
      else $error("first trigger flag dropped without reset");

endmodule

`default_nettype wire

[design/tdcewd_queue.sv]
// Two-entry queue of event snapshots between the time pipeline and the record emitter.
`default_nettype none

module tdcewd_queue #(
   parameter int unsigned CHANNELS = tdcewd_pkg::CHANNELS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   input  tdcewd_pkg::stamp_set_type                 push_stamps,
   input  tdcewd_pkg::chan_store_type [CHANNELS-1:0] push_stores,
   input  logic                                      pop,
   output logic                                      full,
   output logic                                      head_valid,
   output tdcewd_pkg::stamp_set_type                 head_stamps,
   output tdcewd_pkg::chan_store_type [CHANNELS-1:0] head_stores
);
   import tdcewd_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   stamp_set_type                 stamps_ff [QUEUE_DEPTH];
   chan_store_type [CHANNELS-1:0] stores_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]              wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   assign full        = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid  = count_ff != '0;
   assign head_stamps = stamps_ff[rd_ff];
   assign head_stores = stores_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stamps_ff[wr_ff] <= push_stamps;
         stores_ff[wr_ff] <= push_stores;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("snapshot pushed into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("snapshot popped from empty queue");

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

[design/tdcewd_back.sv]
// Record emitter: walks the channels of the head snapshot into the output register.
`default_nettype none

module tdcewd_back #(
   parameter int unsigned CHANNELS = tdcewd_pkg::CHANNELS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      head_valid,
   input  tdcewd_pkg::stamp_set_type                 head_stamps,
   input  tdcewd_pkg::chan_store_type [CHANNELS-1:0] head_stores,
   output logic                                      pop,
   output logic                                      rec_valid,
   input  logic                                      rec_ready,
   output tdcewd_pkg::out_rec_type                   rec
);
   import tdcewd_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   out_rec_type      rec_ff, rec_in;

   chan_store_type cs;
   logic           out_free;
   logic           load;
   logic           last_rec;

   assign cs       = head_stores[idx_ff];
   assign out_free = !valid_ff || rec_ready;
   assign load     = out_free && head_valid;
   assign last_rec = idx_ff == IDX_W'(CHANNELS - 1);
   assign pop      = load && last_rec;

   always_comb begin
      rec_in.channel = CHAN_W'(idx_ff);
      rec_in.lead    = cs.lead;
      rec_in.trail   = cs.trail;
      rec_in.over    = {cs.trail[EDGE_W-1], cs.trail} - {cs.lead[EDGE_W-1], cs.lead};
      rec_in.hits    = cs.hits;
      rec_in.stamp   = head_stamps.stamp;
      rec_in.gap     = head_stamps.gap;
      rec_in.sync    = head_stamps.sync;
      rec_in.ok      = head_stamps.ok;
      rec_in.last    = last_rec;
      valid_in       = valid_ff;
      idx_in         = idx_ff;
      if (out_free) begin
         valid_in = head_valid;
      end
      if (load) begin
         idx_in = last_rec ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_valid = valid_ff;
   assign rec       = rec_ff;

endmodule

`default_nettype wire

[verif/tdc_event_word_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the event word decoder: word streams against a channel record predictor.
module tdc_event_word_decoder_tb;
   import tdcewd_pkg::*;

   localparam int unsigned CH        = CHANNELS_DEFAULT;
   localparam int unsigned DRAIN     = 32;
   localparam int unsigned QUIET_MAX = 1000;
   localparam longint unsigned ROUND_HALF = 64'd20000000;
   localparam longint unsigned TICKS_25NS = 64'd40000000;
   localparam longint unsigned TIME_MAX   = 64'h3fff_ffff_ffff_ffff;
   localparam longint          GAP_MAX    = 64'sh3fff_ffff_ffff_ffff;
   localparam int unsigned LEAD_LO  = 0;
   localparam int unsigned TRAIL_LO = LEAD_LO + EDGE_W;
   localparam int unsigned OVER_LO  = TRAIL_LO + EDGE_W;
   localparam int unsigned HITS_LO  = OVER_LO + TOT_W;
   localparam int unsigned STAMP_LO = HITS_LO + HIT_W;
   localparam int unsigned GAP_LO   = STAMP_LO + TIME_W;
   localparam int unsigned SYNC_LO  = GAP_LO + TIME_W;
   localparam int unsigned FILL_LO  = SYNC_LO + TIME_W;

   class channel_record_book;
      int errors;
      out_rec_type due_records[$];
      logic [HIT_W-1:0]    limit_reg;
      logic [WINDOW_W-1:0] window_reg;
      expect_type          word_mode;
      bit                  open_event;
      bit                  have_origin;
      logic [UPPER_W-1:0]  upper_reg;
      longint unsigned     origin_time;
      longint              last_stamp, stamp_now, gap_now, sync_now;
      logic signed [EDGE_W-1:0] lead_t[CH];
      logic signed [EDGE_W-1:0] trail_t[CH];
      logic [HIT_W-1:0]         hit_n[CH];

      function new();
         errors      = 0;
         limit_reg   = HIT_LIMIT_RESET;
         window_reg  = PULSE_WINDOW_RESET;
         word_mode   = EXP_NORMAL;
         open_event  = 0;
         have_origin = 0;
         upper_reg   = '0;
         origin_time = 0;
         last_stamp  = 0;
         stamp_now   = 0;
         gap_now     = 0;
         sync_now    = 0;
         clear_channels();
      endfunction

      function void clear_channels();
         for (int i = 0; i < CH; i++) begin
            lead_t[i]  = NO_EDGE;
            trail_t[i] = NO_EDGE;
            hit_n[i]   = '0;
         end
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      function void set_reg(reg_index_type idx, logic [CFG_W-1:0] val);
         if (idx == REG_HIT_LIMIT) limit_reg = val[HIT_W-1:0];
         else window_reg = val[WINDOW_W-1:0];
      endfunction

      function longint unsigned net_time(logic [UPPER_W-1:0] up, logic [WORD_W-1:0] lo);
         logic [55:0] full;
         longint unsigned secs, t32k, t25, frac, total;
         full  = {up, lo};
         secs  = full[55:26];
         t32k  = full[25:11];
         t25   = full[10:0];
         frac  = (t32k << 17) + (((t25 << 32) + ROUND_HALF) / TICKS_25NS);
         total = (secs << 32) + frac;
         return (total > TIME_MAX) ? TIME_MAX : total;
      endfunction

      function void take_time(logic [WORD_W-1:0] w);
         longint unsigned t;
         longint g;
         t = net_time(upper_reg, w);
         if (!have_origin) begin
            have_origin = 1;
            origin_time = t;
            stamp_now   = 0;
            gap_now     = 0;
            last_stamp  = 0;
         end else begin
            stamp_now = longint'(t) - longint'(origin_time);
            g = stamp_now - last_stamp;
            if (g > GAP_MAX) g = GAP_MAX;
            else if (g < -GAP_MAX - 1) g = -GAP_MAX - 1;
            gap_now    = g;
            last_stamp = stamp_now;
         end
         if (gap_now < longint'({24'd0, window_reg})) sync_now = stamp_now;
      endfunction

      function void take_edge(logic [WORD_W-1:0] w, bit leading);
         int unsigned ch;
         ch = w[23:16];
         if (ch >= CH || hit_n[ch] >= limit_reg) return;
         if (leading) lead_t[ch] = {1'b0, w[15:0]};
         else trail_t[ch] = {1'b0, w[15:0]};
         hit_n[ch]++;
      endfunction

      function void emit_records(logic [WORD_W-1:0] w);
         out_rec_type rec;
         logic signed [TOT_W-1:0] tot;
         for (int i = 0; i < CH; i++) begin
            tot         = trail_t[i] - lead_t[i];
            rec.channel = CHAN_W'(i);
            rec.lead    = lead_t[i];
            rec.trail   = trail_t[i];
            rec.over    = tot;
            rec.hits    = hit_n[i];
            rec.stamp   = stamp_now[TIME_W-1:0];
            rec.gap     = gap_now[TIME_W-1:0];
            rec.sync    = sync_now[TIME_W-1:0];
            rec.ok      = (w == WORD_STATUS_OK);
            rec.last    = (i == CH - 1);
            due_records.push_back(rec);
         end
      endfunction

      function void note_word(logic [WORD_W-1:0] w);
         case (word_mode)
            EXP_TIME: begin
               word_mode = EXP_NORMAL;
               take_time(w);
            end
            EXP_KEYWORD: begin
               word_mode = EXP_NORMAL;
            end
            EXP_STATUS: begin
               word_mode = EXP_NORMAL;
               emit_records(w);
            end
            default: begin
               if (w[31:24] == TOP_HEADER) begin
                  open_event = 1;
                  clear_channels();
                  upper_reg = w[UPPER_W-1:0];
                  word_mode = EXP_TIME;
               end else if (w == WORD_KEYWORD) begin
                  word_mode = EXP_KEYWORD;
               end else if (open_event) begin
                  if (w[31:24] == TOP_LEAD) take_edge(w, 1);
                  else if (w[31:24] == TOP_TRAIL) take_edge(w, 0);
                  else if (w == WORD_TRAILER) begin
                     open_event = 0;
                     word_mode  = EXP_STATUS;
                  end
               end
            end
         endcase
      endfunction

      task cmp(string name, int ch, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
         if (got !== want)
            report($sformatf("channel %0d %s: got %0h expected %0h", ch, name, got, want));
      endtask

      task check_record(logic [255:0] data, logic [2:0] user, logic tlast);
         out_rec_type want;
         if (due_records.size() == 0) begin
            report($sformatf("record with none expected, tuser %0h", user));
            return;
         end
         want = due_records.pop_front();
         cmp("channel", want.channel, user[1:0], want.channel);
         cmp("lead_time", want.channel, data[LEAD_LO +: EDGE_W], want.lead);
         cmp("trail_time", want.channel, data[TRAIL_LO +: EDGE_W], want.trail);
         cmp("over_threshold", want.channel, data[OVER_LO +: TOT_W], want.over);
         cmp("hit_count", want.channel, data[HITS_LO +: HIT_W], want.hits);
         cmp("stamp", want.channel, data[STAMP_LO +: TIME_W], want.stamp);
         cmp("trigger_gap", want.channel, data[GAP_LO +: TIME_W], want.gap);
         cmp("sync_stamp", want.channel, data[SYNC_LO +: TIME_W], want.sync);
         cmp("event_ok", want.channel, user[2], want.ok);
         cmp("last", want.channel, tlast, want.last);
         cmp("fill", want.channel, data[255:FILL_LO], '0);
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [WORD_W-1:0]       req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [255:0]            rsp_tdata;
   logic [2:0]              rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CFG_INDEX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]        csr_data = '0;

   channel_record_book book;
   int unsigned words_sent = 0;
   int unsigned burst_left = 0;
   int unsigned quiet = 0;
   logic [5:0]  stall_cnt = '0;
   logic [1:0]  stall_mode = '0;
   logic [55:0] run_net = '0;

   tdc_event_word_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1'b1;
      if (stall_cnt == '0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (stall_cnt[1:0] == 2'd0);
         default: rsp_tready <= stall_cnt[3];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_record(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_MAX) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] w);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      book.note_word(w);
      words_sent++;
   endtask

   task automatic push_word(input logic [WORD_W-1:0] w);
      int unsigned pause;
      if (burst_left == 0) begin
         pause = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if (pause != 0) begin
            req_tvalid <= 1'b0;
            repeat (pause) @(posedge clock);
         end
      end
      burst_left--;
      send_word(w);
   endtask

   task automatic hold_until_drained(input int unsigned extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.due_records.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      book.set_reg(idx, val);
   endtask

   task automatic configure(input logic [HIT_W-1:0] limit, input logic [WINDOW_W-1:0] window);
      hold_until_drained(DRAIN);
      write_reg(REG_HIT_LIMIT, CFG_W'(limit));
      write_reg(REG_PULSE_WINDOW, CFG_W'(window));
      csr_valid <= 1'b0;
   endtask

   task automatic random_event();
      int unsigned n_edges, ch;
      bit narrow;
      int unsigned ending;
      logic [WORD_W-1:0] w;
      if ($urandom_range(0, 7) == 0)
         push_word({TOP_LEAD, 8'($urandom_range(0, CH - 1)), 16'($urandom)});
      case ($urandom_range(0, 4))
         0: run_net = run_net + 56'($urandom_range(1, 2047));
         1: run_net = run_net + 56'({$urandom_range(1, 40), 11'd0});
         2: run_net = run_net + 56'({$urandom_range(1, 15), 26'd0});
         3: run_net = 56'({$urandom, $urandom});
         default: run_net = run_net - 56'($urandom_range(1, 5000));
      endcase
      push_word({TOP_HEADER, run_net[55:32]});
      push_word(run_net[31:0]);
      n_edges = $urandom_range(0, 24);
      narrow  = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < n_edges; k++) begin
         if ($urandom_range(0, 19) == 0) begin
            push_word(WORD_KEYWORD);
            push_word($urandom);
         end else begin
            if ($urandom_range(0, 9) == 0) ch = $urandom_range(CH, 255);
            else if (narrow) ch = $urandom_range(0, 1);
            else ch = $urandom_range(0, CH - 1);
            w = {($urandom_range(0, 1) ? TOP_LEAD : TOP_TRAIL), 8'(ch), 16'($urandom)};
            push_word(w);
         end
      end
      ending = $urandom_range(0, 99);
      if (ending < 90) begin
         push_word(WORD_TRAILER);
         case ($urandom_range(0, 4))
            0: push_word($urandom);
            1: push_word(WORD_STATUS_OK ^ (32'd1 << $urandom_range(0, 31)));
            default: push_word(WORD_STATUS_OK);
         endcase
      end else if (ending < 95) begin
         push_word(WORD_TRAILER);
      end
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned start;
      start = words_sent;
      while (words_sent - start < quota) begin
         if ($urandom_range(0, 9) == 0) push_word($urandom);
         else random_event();
      end
   endtask

   initial begin
      book = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      push_word({TOP_LEAD, 8'd1, 16'h0001});
      push_word(WORD_TRAILER);
      push_word({TOP_HEADER, 24'h800000});
      push_word(32'h0000_0000);
      push_word({TOP_LEAD, 8'd0, 16'h0000});
      push_word({TOP_TRAIL, 8'd0, 16'hffff});
      push_word({TOP_LEAD, 8'd3, 16'hffff});
      push_word({TOP_TRAIL, 8'd3, 16'h0000});
      push_word({TOP_LEAD, 8'd4, 16'h0005});
      push_word({TOP_TRAIL, 8'hff, 16'h1234});
      push_word(WORD_KEYWORD);
      push_word(WORD_TRAILER);
      push_word(WORD_TRAILER);
      push_word(WORD_STATUS_OK);
      push_word({TOP_HEADER, 24'h000000});
      push_word(32'hffff_ffff);
      push_word({TOP_HEADER, 24'hffffff});
      push_word(32'hffff_ffff);
      push_word(WORD_TRAILER);
      push_word(32'h0002_0000);
      push_word({TOP_HEADER, 24'h800000});
      push_word(32'h0000_0801);
      push_word({TOP_HEADER, 24'h800000});
      push_word(32'h0000_0802);
      push_word(WORD_TRAILER);
      push_word({TOP_HEADER, 24'h000000});
      run_net = {24'h800000, 32'h0000_0802};

      configure(8'd0, '0);
      random_phase(35);
      configure(8'hff, '1);
      random_phase(45);
      configure(8'd2, 40'($urandom_range(1, 32'h00ff_ffff)));
      random_phase(30);
      hold_until_drained(0);
      random_phase(20);
      configure(HIT_LIMIT_RESET, PULSE_WINDOW_RESET);
      random_phase(65);

      hold_until_drained(DRAIN);
      if (book.errors == 0 && book.due_records.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
